// File: rtl/srev_pkg.sv
package srev_pkg;

	// Fixed structure of the reverb
	localparam int NUM_COMBS   = 4;
	localparam int NUM_ALLPASS = 2;
	localparam int NUM_LINES   = NUM_COMBS + NUM_ALLPASS;
	localparam int LINE_W      = 3;

	// Defaults for the top level parameters
	localparam int SAMPLE_RATE_DEF = 48000;
	localparam int DELAY_DEPTH_DEF = 4096;

	// Delay times in ms, combs first, then all-passes
	localparam int LINE_MS [NUM_LINES] = '{35, 37, 41, 43, 6, 17};

	// All-pass gain 0.7 in Q0.15
	localparam logic signed [16:0] AP_GAIN = 17'sd22938;

	// Delay divide: N / (1000 * 16384) = ((N >> 17) / 125), reciprocal of 125
	localparam int DIV_SHIFT = 17;
	localparam int RECIP_125 = 16778;
	localparam int RECIP_SH  = 21;
	localparam int DIVISOR   = 125;

	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_A = 3'd0,
		REG_GAIN_B = 3'd1,
		REG_GAIN_C = 3'd2,
		REG_GAIN_D = 3'd3,
		REG_ROOM   = 3'd4,
		REG_DAMP   = 3'd5,
		REG_WET    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_COMBS-1:0][14:0] gain;
		logic [14:0]                room;
		logic [14:0]                damp;
		logic [15:0]                wet;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_C_PREP,
		ST_C_DIV,
		ST_C_FIX,
		ST_A_PREP,
		ST_MEM,
		ST_UPD,
		ST_MIX,
		ST_SAT,
		ST_DONE
	} state_t;

	// Q15 product, rounds half up: floor((a*g + 16384) / 32768)
	function automatic logic signed [18:0] mul_q15(input logic signed [16:0] a,
	                                               input logic signed [16:0] g);
		logic signed [33:0] p;
		p = a * g + 34'sd16384;
		return p[33:15];
	endfunction

	// Saturate to 16-bit signed
	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767)
			return 16'sh7fff;
		else if (v < -20'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

// File: rtl/srev_dmem.sv
module srev_dmem #(
	parameter int WORDS = 6 * srev_pkg::DELAY_DEPTH_DEF,
	parameter int AW    = $clog2(WORDS)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [15:0]  wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [15:0]  rdata
);

	logic signed [15:0] mem [WORDS];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/srev_core.sv
module srev_core #(
	parameter int SAMPLE_RATE = srev_pkg::SAMPLE_RATE_DEF,
	parameter int DELAY_DEPTH = srev_pkg::DELAY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srev_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_sample,
	input  logic               in_restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_sample
);

	localparam int WORDS = srev_pkg::NUM_LINES * DELAY_DEPTH;
	localparam int MAW   = $clog2(WORDS);
	localparam int AW    = $clog2(DELAY_DEPTH);
	localparam int DMAX  = DELAY_DEPTH - 1;
	localparam int AP_D0 = (srev_pkg::LINE_MS[4] * SAMPLE_RATE / 1000 > DMAX) ? DMAX
	                       : srev_pkg::LINE_MS[4] * SAMPLE_RATE / 1000;
	localparam int AP_D1 = (srev_pkg::LINE_MS[5] * SAMPLE_RATE / 1000 > DMAX) ? DMAX
	                       : srev_pkg::LINE_MS[5] * SAMPLE_RATE / 1000;
	localparam logic [20:0] KMS0 = 21'(srev_pkg::LINE_MS[0] * SAMPLE_RATE);
	localparam logic [20:0] KMS1 = 21'(srev_pkg::LINE_MS[1] * SAMPLE_RATE);
	localparam logic [20:0] KMS2 = 21'(srev_pkg::LINE_MS[2] * SAMPLE_RATE);
	localparam logic [20:0] KMS3 = 21'(srev_pkg::LINE_MS[3] * SAMPLE_RATE);

	srev_pkg::state_t state_q, state_d;

	logic [srev_pkg::LINE_W-1:0] line_q;
	logic [MAW-1:0]              clr_q;
	logic                        run_q;
	logic [AW-1:0]               wp_q [srev_pkg::NUM_LINES];
	logic signed [15:0]          lp_q [srev_pkg::NUM_COMBS];
	logic signed [15:0]          prev_q [srev_pkg::NUM_ALLPASS];
	logic signed [15:0]          x_q;
	logic signed [15:0]          fed_q;
	logic signed [15:0]          ap_q;
	logic signed [18:0]          apg_q;
	logic signed [17:0]          sum_q;
	logic [AW-1:0]               d_q;
	logic [18:0]                 m_s1;
	logic [12:0]                 q_s2;
	logic signed [33:0]          p1_q, p2_q;
	logic signed [15:0]          res_q;
	logic                        oval_q;
	logic signed [15:0]          odata_q;

	// Memory port signals
	logic               mem_we;
	logic [MAW-1:0]     mem_waddr, mem_raddr;
	logic signed [15:0] mem_wdata, mem_rdata;

	// Derived values for the current line
	logic [MAW-1:0]     base;
	logic [AW-1:0]      wp, rp;
	logic [1:0]         ci;
	logic               ai;
	logic [20:0]        kms;
	logic signed [16:0] coef;
	logic signed [15:0] dly;
	logic signed [15:0] lp_new;
	logic signed [17:0] sum_new;
	logic [12:0]        qc;
	logic [16:0]        mix;
	logic signed [34:0] acc;
	logic               accept;

	assign ci     = line_q[1:0];
	assign ai     = line_q[0];
	assign wp     = wp_q[line_q];
	assign base   = MAW'(line_q * DELAY_DEPTH);
	assign coef   = $signed(17'd32768 - {2'b00, cfg.damp});
	assign accept = in_valid && in_ready;

	assign in_ready   = (state_q == srev_pkg::ST_IDLE);
	assign out_valid  = oval_q;
	assign out_sample = odata_q;

	// Read position, wrapping at the line length
	always_comb begin
		if (wp >= d_q)
			rp = wp - d_q;
		else
			rp = AW'((AW+1)'(wp) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(d_q));
	end

	// Per-comb delay constant ms * rate
	always_comb begin
		unique case (ci)
			2'd0: kms = KMS0;
			2'd1: kms = KMS1;
			2'd2: kms = KMS2;
			default: kms = KMS3;
		endcase
	end

	// Reciprocal quotient correction
	always_comb begin
		if (23'(q_s2) * 23'(srev_pkg::DIVISOR) > 23'(m_s1))
			qc = q_s2 - 13'd1;
		else
			qc = q_s2;
	end

	// Zero delay reads the value just written
	assign dly = (d_q == '0) ? fed_q : mem_rdata;

	assign lp_new = srev_pkg::sat16(20'(lp_q[ci]) +
		20'(srev_pkg::mul_q15(17'(dly) - 17'(lp_q[ci]), coef)));
	assign sum_new = sum_q + 18'(lp_new);

	assign mix = (cfg.wet > 16'd32768) ? 17'd32768 : {1'b0, cfg.wet};
	assign acc = 35'(p1_q) + 35'(p2_q) + 35'sd16384;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srev_pkg::ST_IDLE:
				if (accept)
					state_d = in_restart ? srev_pkg::ST_CLEAR : srev_pkg::ST_C_PREP;
			srev_pkg::ST_CLEAR:
				if (clr_q == MAW'(WORDS - 1))
					state_d = run_q ? srev_pkg::ST_C_PREP : srev_pkg::ST_IDLE;
			srev_pkg::ST_C_PREP: state_d = srev_pkg::ST_C_DIV;
			srev_pkg::ST_C_DIV:  state_d = srev_pkg::ST_C_FIX;
			srev_pkg::ST_C_FIX:  state_d = srev_pkg::ST_MEM;
			srev_pkg::ST_A_PREP: state_d = srev_pkg::ST_MEM;
			srev_pkg::ST_MEM:    state_d = srev_pkg::ST_UPD;
			srev_pkg::ST_UPD: begin
				if (line_q == srev_pkg::LINE_W'(srev_pkg::NUM_LINES - 1))
					state_d = srev_pkg::ST_MIX;
				else if (line_q >= srev_pkg::LINE_W'(srev_pkg::NUM_COMBS - 1))
					state_d = srev_pkg::ST_A_PREP;
				else
					state_d = srev_pkg::ST_C_PREP;
			end
			srev_pkg::ST_MIX: state_d = srev_pkg::ST_SAT;
			srev_pkg::ST_SAT: state_d = srev_pkg::ST_DONE;
			srev_pkg::ST_DONE:
				if (!oval_q || out_ready)
					state_d = srev_pkg::ST_IDLE;
			default: state_d = srev_pkg::ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base + MAW'(wp);
		mem_wdata = fed_q;
		mem_raddr = base + MAW'(rp);
		unique case (state_q)
			srev_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			srev_pkg::ST_MEM: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srev_pkg::ST_CLEAR;
			clr_q   <= '0;
			run_q   <= 1'b0;
			line_q  <= '0;
			oval_q  <= 1'b0;
			for (int i = 0; i < srev_pkg::NUM_LINES; i++)
				wp_q[i] <= '0;
			for (int i = 0; i < srev_pkg::NUM_COMBS; i++)
				lp_q[i] <= '0;
			for (int i = 0; i < srev_pkg::NUM_ALLPASS; i++)
				prev_q[i] <= '0;
		end else begin
			state_q <= state_d;
			// Output register: load a new result or drop the one taken
			if (state_q == srev_pkg::ST_DONE && (!oval_q || out_ready))
				oval_q <= 1'b1;
			else if (oval_q && out_ready)
				oval_q <= 1'b0;
			unique case (state_q)
				srev_pkg::ST_IDLE: begin
					line_q <= '0;
					clr_q  <= '0;
					if (accept && in_restart) begin
						run_q <= 1'b1;
						for (int i = 0; i < srev_pkg::NUM_LINES; i++)
							wp_q[i] <= '0;
						for (int i = 0; i < srev_pkg::NUM_COMBS; i++)
							lp_q[i] <= '0;
						for (int i = 0; i < srev_pkg::NUM_ALLPASS; i++)
							prev_q[i] <= '0;
					end
				end
				srev_pkg::ST_CLEAR: clr_q <= clr_q + MAW'(1);
				srev_pkg::ST_MEM: begin
					if (wp == AW'(DMAX))
						wp_q[line_q] <= '0;
					else
						wp_q[line_q] <= wp + AW'(1);
				end
				srev_pkg::ST_UPD: begin
					line_q <= line_q + srev_pkg::LINE_W'(1);
					if (line_q < srev_pkg::LINE_W'(srev_pkg::NUM_COMBS))
						lp_q[ci] <= lp_new;
					else
						prev_q[ai] <= dly;
				end
				srev_pkg::ST_DONE: run_q <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			srev_pkg::ST_IDLE: begin
				sum_q <= '0;
				if (accept)
					x_q <= in_sample;
			end
			srev_pkg::ST_C_PREP: begin
				m_s1  <= 19'((36'({21'd0, cfg.room}) * 36'(kms)) >> srev_pkg::DIV_SHIFT);
				fed_q <= srev_pkg::sat16(20'(x_q) + 20'(srev_pkg::mul_q15(17'(lp_q[ci]),
					$signed({2'b00, cfg.gain[ci]}))));
			end
			srev_pkg::ST_C_DIV:
				q_s2 <= 13'((34'(m_s1) * 34'(srev_pkg::RECIP_125)) >> srev_pkg::RECIP_SH);
			srev_pkg::ST_C_FIX: begin
				if (32'(qc) > 32'(DMAX))
					d_q <= AW'(DMAX);
				else
					d_q <= AW'(qc);
			end
			srev_pkg::ST_A_PREP: begin
				fed_q <= srev_pkg::sat16(20'(ap_q) +
					20'(srev_pkg::mul_q15(17'(prev_q[ai]), srev_pkg::AP_GAIN)));
				apg_q <= srev_pkg::mul_q15(17'(ap_q), srev_pkg::AP_GAIN);
				d_q   <= ai ? AW'(AP_D1) : AW'(AP_D0);
			end
			srev_pkg::ST_UPD: begin
				if (line_q < srev_pkg::LINE_W'(srev_pkg::NUM_COMBS)) begin
					sum_q <= sum_new;
					if (line_q == srev_pkg::LINE_W'(srev_pkg::NUM_COMBS - 1))
						ap_q <= srev_pkg::sat16((20'(sum_new) + 20'sd2) >>> 2);
				end else begin
					ap_q <= srev_pkg::sat16(20'(dly) - 20'(apg_q));
				end
			end
			srev_pkg::ST_MIX: begin
				p1_q <= 34'(x_q) * 34'($signed({1'b0, 17'(17'd32768 - mix)}));
				p2_q <= 34'(ap_q) * 34'($signed({1'b0, mix}));
			end
			srev_pkg::ST_SAT: res_q <= srev_pkg::sat16(acc[34:15]);
			srev_pkg::ST_DONE:
				if (!oval_q || out_ready)
					odata_q <= res_q;
			default: begin
			end
		endcase
	end

	srev_dmem #(
		.WORDS(WORDS),
		.AW   (MAW)
	) u_dmem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// File: rtl/schroeder_reverb_top.sv
// Schroeder reverb: four damped combs into two all-passes, dry/wet mix, Q1.15.
// All six delay lines share one memory of 6*DELAY_DEPTH words (one write and one
// registered read per cycle); a sequencer walks the lines one after another with
// a read-modify-write of each. Per sample, each comb divides for its delay by
// reciprocal, accesses memory and updates its low-pass, each all-pass accesses
// memory, then the dry/wet mix is saturated into the output register.
// A new sample is taken once the previous result is in the output register.
// After reset, and before a sample that has restart set, the memory is swept to
// zero over all 6*DELAY_DEPTH words, during which no sample is accepted.
// Configuration is taken at any time but must be written only while idle.
module schroeder_reverb_top #(
	parameter int SAMPLE_RATE = srev_pkg::SAMPLE_RATE_DEF,
	parameter int DELAY_DEPTH = srev_pkg::DELAY_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // [15:0] sample_in
	input  logic                        s_axis_tuser,  // [0] restart
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [15:0]                 m_axis_tdata,  // [15:0] sample_out
	input  logic                        cfg_we,
	input  logic [srev_pkg::IDX_W-1:0]  cfg_index,
	input  logic [srev_pkg::CFG_W-1:0]  cfg_data
);

	srev_pkg::cfg_t     cfg_q;
	logic signed [15:0] out_s;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srev_pkg::NUM_COMBS; i++)
				cfg_q.gain[i] <= 15'd26214;
			cfg_q.room <= 15'd16384;
			cfg_q.damp <= 15'd16384;
			cfg_q.wet  <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srev_pkg::REG_GAIN_A: cfg_q.gain[0] <= cfg_data[14:0];
				srev_pkg::REG_GAIN_B: cfg_q.gain[1] <= cfg_data[14:0];
				srev_pkg::REG_GAIN_C: cfg_q.gain[2] <= cfg_data[14:0];
				srev_pkg::REG_GAIN_D: cfg_q.gain[3] <= cfg_data[14:0];
				srev_pkg::REG_ROOM:   cfg_q.room    <= cfg_data[14:0];
				srev_pkg::REG_DAMP:   cfg_q.damp    <= cfg_data[14:0];
				srev_pkg::REG_WET:    cfg_q.wet     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	srev_core #(
		.SAMPLE_RATE(SAMPLE_RATE),
		.DELAY_DEPTH(DELAY_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample ($signed(s_axis_tdata)),
		.in_restart(s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sample(out_s)
	);

	assign m_axis_tdata = out_s;

endmodule
